[design/pltc_pkg.sv]
`timescale 1ns / 1ps

package pltc_pkg;

	localparam int DEF_TABLE_ROWS = 64;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_COUNT  = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	// One stored row: key fields in network order, hit count and timestamp.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  protocol;
		logic [7:0]  action;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  reason;
		logic [31:0] hits;
		logic [31:0] tstamp;
	} entry_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

[design/pltc_ram.sv]
`timescale 1ns / 1ps

module pltc_ram
	import pltc_pkg::*;
#(
	parameter int DEPTH = DEF_TABLE_ROWS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/packet_log_match_count_table_core.sv]
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  op, protocol, action, src_addr, dst_addr, src_port_in,
//                               dst_port_in, verdict_reason, now_seconds, row_index
// out      out_valid / out_stall status, rows_used, row_protocol, row_action, row_src_addr,
//                               row_dst_addr, row_src_port, row_dst_port, row_reason,
//                               row_hits, row_time
//
// An update scans the used rows through the single table read port, one key compare per
// cycle, and ends the scan early on a match. A row read passes through ST_RDREQ and
// ST_RDOUT, a row count or clear through ST_RESP.
// One request at a time; in_stall is high from accept until its result is registered.
// Reset clears the row count and control; table contents are not cleared.
// A stalled result holds in the output register; the next request is taken meanwhile.

module packet_log_match_count_table_core
	import pltc_pkg::*;
#(
	parameter int TABLE_ROWS = DEF_TABLE_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [7:0]         protocol,
	input  logic [7:0]         action,
	input  logic [31:0]        src_addr,
	input  logic [31:0]        dst_addr,
	input  logic [15:0]        src_port_in,
	input  logic [15:0]        dst_port_in,
	input  logic signed [7:0]  verdict_reason,
	input  logic [31:0]        now_seconds,
	input  logic [5:0]         row_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [6:0]         rows_used,
	output logic [7:0]         row_protocol,
	output logic [7:0]         row_action,
	output logic [31:0]        row_src_addr,
	output logic [31:0]        row_dst_addr,
	output logic [15:0]        row_src_port,
	output logic [15:0]        row_dst_port,
	output logic signed [7:0]  row_reason,
	output logic [31:0]        row_hits,
	output logic [31:0]        row_time
);

	localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int IW = $clog2(TABLE_ROWS + 1);
	localparam int CW = (IW > 6) ? IW : 6;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_UPD   = 6'b000100,
		ST_RDREQ = 6'b001000,
		ST_RDOUT = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t        state_q;
	op_t           op_q;
	stat_t         stat_q;
	entry_t        key_q;
	logic [5:0]    row_index_q;
	logic [IW-1:0] rows_q;
	logic [IW-1:0] rows_next;
	logic [IW-1:0] scan_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	logic          in_acc;
	logic          slot_free;
	logic          finish;
	logic          out_load;
	logic          issue;
	logic          match;
	logic          full;
	logic          idx_range;
	logic [CW-1:0] idx_ext;

	entry_t        rd_data;
	entry_t        wr_data;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;

	stat_t         res_status;
	entry_t        res_row;

	logic          out_valid_q;
	stat_t         status_q;
	logic [6:0]    rows_used_q;
	entry_t        row_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign finish    = (state_q == ST_UPD) || (state_q == ST_RDOUT) || (state_q == ST_RESP);
	assign out_load  = finish && slot_free;

	// shared key comparator, fed from the table read port
	assign match = (rd_data.src_addr == key_q.src_addr) &&
		(rd_data.dst_addr == key_q.dst_addr) &&
		(rd_data.protocol == key_q.protocol) &&
		(rd_data.action == key_q.action) &&
		(rd_data.sport == key_q.sport) &&
		(rd_data.dport == key_q.dport) &&
		(rd_data.reason == key_q.reason);

	// stop issuing once a match is seen so the matched row stays in the read register
	assign issue = (state_q == ST_SCAN) && (scan_q < rows_q) && !(rd_vld_s1 && match);
	assign full  = (rows_q >= IW'(TABLE_ROWS));

	assign idx_ext   = CW'(row_index);
	assign idx_range = (idx_ext >= CW'(rows_q));

	assign ram_re    = issue || (state_q == ST_RDREQ);
	assign ram_raddr = (state_q == ST_SCAN) ? scan_q[AW-1:0] : AW'(row_index_q);
	assign ram_we    = out_load && (state_q == ST_UPD) && (hit_q || !full);
	assign ram_waddr = hit_q ? hit_idx_q : rows_q[AW-1:0];

	always_comb begin
		wr_data = key_q;
		if (hit_q) begin
			wr_data.hits = (rd_data.hits == '1) ? rd_data.hits : rd_data.hits + 32'd1;
		end else begin
			wr_data.hits = 32'd1;
		end
		wr_data.tstamp = key_q.tstamp;
	end

	pltc_ram #(
		.DEPTH (TABLE_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		rows_next = rows_q;
		if (out_load) begin
			if ((state_q == ST_UPD) && !hit_q && !full) begin
				rows_next = rows_q + IW'(1);
			end else if ((state_q == ST_RESP) && (op_q == OP_CLEAR)) begin
				rows_next = '0;
			end
		end
	end

	always_comb begin
		res_status = stat_q;
		res_row    = '0;
		case (state_q)
			ST_UPD: begin
				res_status = (!hit_q && full) ? STAT_FULL : STAT_OK;
			end
			ST_RDOUT: begin
				res_status       = STAT_OK;
				res_row.protocol = rd_data.protocol;
				res_row.action   = rd_data.action;
				res_row.src_addr = swap32(rd_data.src_addr);
				res_row.dst_addr = swap32(rd_data.dst_addr);
				res_row.sport    = swap16(rd_data.sport);
				res_row.dport    = swap16(rd_data.dport);
				res_row.reason   = rd_data.reason;
				res_row.hits     = rd_data.hits;
				res_row.tstamp   = rd_data.tstamp;
			end
			default: begin
				res_status = stat_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rows_q    <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			op_q      <= OP_UPDATE;
			stat_q    <= STAT_OK;
		end else begin
			rows_q    <= rows_next;
			rd_vld_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + IW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q   <= op_t'(op);
						stat_q <= STAT_OK;
						hit_q  <= 1'b0;
						scan_q <= '0;
						case (op_t'(op))
							OP_UPDATE: state_q <= ST_SCAN;
							OP_READ: begin
								if (idx_range) begin
									stat_q  <= STAT_RANGE;
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_RDREQ;
								end
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1 && match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPD;
					end else if (!issue && !rd_vld_s1) begin
						state_q <= ST_UPD;
					end
				end
				ST_RDREQ: state_q <= ST_RDOUT;
				ST_UPD, ST_RDOUT, ST_RESP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q.src_addr <= src_addr;
			key_q.dst_addr <= dst_addr;
			key_q.protocol <= protocol;
			key_q.action   <= action;
			key_q.sport    <= src_port_in;
			key_q.dport    <= dst_port_in;
			key_q.reason   <= verdict_reason;
			key_q.hits     <= 32'd0;
			key_q.tstamp   <= now_seconds;
			row_index_q    <= row_index;
		end
		if (issue) begin
			rd_idx_s1 <= scan_q[AW-1:0];
		end
		if ((state_q == ST_SCAN) && rd_vld_s1 && match) begin
			hit_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= res_status;
			rows_used_q <= 7'(rows_next);
			row_q       <= res_row;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign rows_used    = rows_used_q;
	assign row_protocol = row_q.protocol;
	assign row_action   = row_q.action;
	assign row_src_addr = row_q.src_addr;
	assign row_dst_addr = row_q.dst_addr;
	assign row_src_port = row_q.sport;
	assign row_dst_port = row_q.dport;
	assign row_reason   = row_q.reason;
	assign row_hits     = row_q.hits;
	assign row_time     = row_q.tstamp;

`ifndef ASSERT_OFF
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= IW'(TABLE_ROWS))
		else $error("row count beyond table size");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (res_status == STAT_FULL) |-> full && !hit_q)
		else $error("full status with free rows or a match");

	a_write_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_UPD) && (op_q == OP_UPDATE))
		else $error("table write outside an update");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (scan_q < rows_q) && !in_acc)
		else $error("scan read beyond used rows");
`endif

endmodule
